/* src/stks_pkg.sv */
// types, constants and key functions shared by the top-k selector
package stks_pkg;

   localparam int TOP_COUNT     = 4;
   localparam int POSITION_BITS = 16;
   localparam int VALUE_BITS    = 32;
   localparam int RANK_BITS     = 2;
   localparam int IDX_BITS      = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;
   localparam int CNT_BITS      = $clog2(TOP_COUNT + 1);
   localparam int QUEUE_DEPTH   = 4;
   localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

   localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

   typedef enum logic {
      ST_COLLECT,
      ST_EMIT
   } back_state_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0]    bits;
      logic [VALUE_BITS-1:0]    key;
      logic [POSITION_BITS-1:0] pos;
      logic                     last;
      logic                     nan;
   } sample_type;

   typedef struct packed {
      logic [RANK_BITS-1:0]     rank;
      logic [POSITION_BITS-1:0] position;
      logic [VALUE_BITS-1:0]    kept_bits;
      logic                     final_result;
   } result_type;

   // order-preserving key, both zeros share one key
   function automatic logic [VALUE_BITS-1:0] order_key(input logic [VALUE_BITS-1:0] bits);
      logic [VALUE_BITS-1:0] key;
      if (bits[VALUE_BITS-2:0] == '0) begin
         key = {1'b1, {(VALUE_BITS-1){1'b0}}};
      end else if (bits[VALUE_BITS-1]) begin
         key = ~bits;
      end else begin
         key = {1'b1, bits[VALUE_BITS-2:0]};
      end
      return key;
   endfunction

   function automatic logic is_nan(input logic [VALUE_BITS-1:0] bits);
      return (bits[30:23] == 8'hFF) && (bits[22:0] != 23'd0);
   endfunction

endpackage

/* src/stks_req_if.sv */
// request channel of the top-k selector
interface stks_req_if;
   import stks_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] sample_bits;
   logic                  end_of_vector;

   modport source (output valid, output sample_bits, output end_of_vector, input ready);
   modport sink   (input valid, input sample_bits, input end_of_vector, output ready);

endinterface

/* src/stks_rsp_if.sv */
// result channel of the top-k selector
interface stks_rsp_if;
   import stks_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [RANK_BITS-1:0]     rank;
   logic [POSITION_BITS-1:0] position;
   logic [VALUE_BITS-1:0]    kept_bits;
   logic                     final_result;

   modport source (output valid, output rank, output position, output kept_bits,
                   output final_result, input ready);
   modport sink   (input valid, input rank, input position, input kept_bits,
                   input final_result, output ready);

endinterface

/* src/stream_top_k_selector_unit.sv */
// top level of the streaming top-k selector
//
// req channel: one single-precision bit pattern per request, end_of_vector on the
// last element of a vector. rsp channel: on the last element the kept entries come
// out largest first, one per result, with rank, position and the original pattern;
// final_result marks the last of them. NaNs are dropped, ties go to lower position.
// A vector of only NaNs gives no results.
// the front end takes one request per cycle into a four-entry queue while it is not
// full; the back end inserts one queued element per cycle into the sorted list
// while it collects, so a vector streams at one element per cycle. while a vector is
// emitted, the queue keeps taking the next vector's elements until it is full.
// with an empty queue the last request passes through the queue, the back-end state
// and the output register before the first result is valid; then results follow at
// one per cycle while rsp ready stays high. a stalled receiver holds the output
// register and keeps the back end in emission, so the queue fills up and req ready
// drops. reset empties the queue, the list and the output register and restarts
// positions at zero; no clearing pass is needed.
module stream_top_k_selector_unit
   import stks_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   stks_req_if.sink   req,
   stks_rsp_if.source rsp
);

   logic       push;
   sample_type push_item;
   logic       queue_full;
   logic       pop;
   logic       head_valid;
   sample_type head_item;

   stks_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   stks_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   stks_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop),
      .rsp        (rsp)
   );

endmodule

/* src/stks_front.sv */
// front end: accepts requests, numbers and classifies them
module stks_front
   import stks_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   stks_req_if.sink   req,
   input  logic       queue_full,
   output logic       push,
   output sample_type push_item
);

   logic [POSITION_BITS-1:0] counter_ff;
   logic [POSITION_BITS-1:0] counter_in;

   assign req.ready = !queue_full;
   assign push      = req.valid && req.ready;

   always_comb begin
      counter_in = counter_ff;
      if (push) begin
         if (req.end_of_vector) begin
            counter_in = '0;
         end else if (counter_ff != POS_MAX) begin
            counter_in = counter_ff + 1'b1;
         end
      end
      push_item.bits = req.sample_bits;
      push_item.key  = order_key(req.sample_bits);
      push_item.pos  = counter_ff;
      push_item.last = req.end_of_vector;
      push_item.nan  = is_nan(req.sample_bits);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff <= '0;
      end else begin
         counter_ff <= counter_in;
      end
   end

endmodule

/* src/stks_queue.sv */
// short queue between the front end and the back end
module stks_queue
   import stks_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  sample_type push_item,
   output logic       full,
   input  logic       pop,
   output logic       head_valid,
   output sample_type head_item
);

   sample_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff;
   logic [QPTR_BITS-1:0] wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff;
   logic [QPTR_BITS-1:0] rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff;
   logic [QCNT_BITS-1:0] count_in;

   assign full       = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* src/stks_back.sv */
// back end: sorted insertion into the kept list and ranked emission
module stks_back
   import stks_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  sample_type head_item,
   output logic       pop,
   stks_rsp_if.source rsp
);

   back_state_type           state_ff;
   back_state_type           state_in;
   logic [CNT_BITS-1:0]      fill_ff;
   logic [CNT_BITS-1:0]      fill_in;
   logic [IDX_BITS-1:0]      emit_ff;
   logic [IDX_BITS-1:0]      emit_in;
   logic                     out_valid_ff;
   logic                     out_valid_in;
   result_type               out_ff;
   result_type               out_in;
   logic [VALUE_BITS-1:0]    key_ff  [TOP_COUNT];
   logic [VALUE_BITS-1:0]    key_in  [TOP_COUNT];
   logic [VALUE_BITS-1:0]    bits_ff [TOP_COUNT];
   logic [VALUE_BITS-1:0]    bits_in [TOP_COUNT];
   logic [POSITION_BITS-1:0] pos_ff  [TOP_COUNT];
   logic [POSITION_BITS-1:0] pos_in  [TOP_COUNT];
   logic [VALUE_BITS-1:0]    sh_key  [TOP_COUNT];
   logic [VALUE_BITS-1:0]    sh_bits [TOP_COUNT];
   logic [POSITION_BITS-1:0] sh_pos  [TOP_COUNT];
   logic [TOP_COUNT-1:0]     ge;
   logic                     prev_ge;
   logic [CNT_BITS-1:0]      next_fill;
   logic                     emit_last;

   assign rsp.valid        = out_valid_ff;
   assign rsp.rank         = out_ff.rank;
   assign rsp.position     = out_ff.position;
   assign rsp.kept_bits    = out_ff.kept_bits;
   assign rsp.final_result = out_ff.final_result;

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      emit_in      = emit_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      pop          = 1'b0;
      key_in       = key_ff;
      bits_in      = bits_ff;
      pos_in       = pos_ff;
      prev_ge      = 1'b1;
      emit_last    = (CNT_BITS'(emit_ff) + 1'b1) == fill_ff;
      next_fill    = (fill_ff != CNT_BITS'(TOP_COUNT)) ? fill_ff + 1'b1 : fill_ff;

      // entries ranked ahead of the newcomer: kept keys not below it
      for (int i = 0; i < TOP_COUNT; i++) begin
         ge[i] = (CNT_BITS'(i) < fill_ff) && (key_ff[i] >= head_item.key);
      end
      sh_key[0]  = head_item.key;
      sh_bits[0] = head_item.bits;
      sh_pos[0]  = head_item.pos;
      for (int i = 1; i < TOP_COUNT; i++) begin
         sh_key[i]  = key_ff[i-1];
         sh_bits[i] = bits_ff[i-1];
         sh_pos[i]  = pos_ff[i-1];
      end

      case (state_ff)
         ST_COLLECT: begin
            pop = head_valid;
            if (head_valid) begin
               if (!head_item.nan) begin
                  for (int i = 0; i < TOP_COUNT; i++) begin
                     if (!ge[i]) begin
                        if (prev_ge) begin
                           key_in[i]  = head_item.key;
                           bits_in[i] = head_item.bits;
                           pos_in[i]  = head_item.pos;
                        end else begin
                           key_in[i]  = sh_key[i];
                           bits_in[i] = sh_bits[i];
                           pos_in[i]  = sh_pos[i];
                        end
                     end
                     prev_ge = ge[i];
                  end
                  fill_in = next_fill;
               end
               if (head_item.last) begin
                  emit_in = '0;
                  if (head_item.nan && fill_ff == '0) begin
                     fill_in = '0;
                  end else begin
                     state_in = ST_EMIT;
                  end
               end
            end
         end
         ST_EMIT: begin
            if (!out_valid_ff || rsp.ready) begin
               out_valid_in        = 1'b1;
               out_in.rank         = RANK_BITS'(emit_ff);
               out_in.position     = pos_ff[emit_ff];
               out_in.kept_bits    = bits_ff[emit_ff];
               out_in.final_result = emit_last;
               emit_in             = emit_ff + 1'b1;
               if (emit_last) begin
                  fill_in  = '0;
                  emit_in  = '0;
                  state_in = ST_COLLECT;
               end
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_COLLECT;
         fill_ff      <= '0;
         emit_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         emit_ff      <= emit_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      key_ff  <= key_in;
      bits_ff <= bits_in;
      pos_ff  <= pos_in;
   end

endmodule

/* tb/stream_top_k_selector_unit_test.sv */
// self-checking testbench for the streaming top-k selector: directed and random vectors
module stream_top_k_selector_unit_test;
   import stks_pkg::*;

   localparam int CYCLE_LIMIT  = 40000;
   localparam int HOLD_CYCLES  = 120;
   localparam int HOLD_AFTER   = 60;
   localparam int RANDOM_ITEMS = 320;
   localparam int IDLE_PERCENT = 22;
   localparam int TIE_COUNT    = 5;
   localparam int EXTREME_COUNT = 6;

   localparam logic [VALUE_BITS-1:0] FP_POS_ZERO = 32'h0000_0000;
   localparam logic [VALUE_BITS-1:0] FP_NEG_ZERO = 32'h8000_0000;
   localparam logic [VALUE_BITS-1:0] FP_POS_ONE  = 32'h3F80_0000;
   localparam logic [VALUE_BITS-1:0] FP_NEG_ONE  = 32'hBF80_0000;
   localparam logic [VALUE_BITS-1:0] FP_POS_TWO  = 32'h4000_0000;
   localparam logic [VALUE_BITS-1:0] FP_POS_INF  = 32'h7F80_0000;
   localparam logic [VALUE_BITS-1:0] FP_NEG_INF  = 32'hFF80_0000;
   localparam logic [VALUE_BITS-1:0] FP_POS_MAX  = 32'h7F7F_FFFF;
   localparam logic [VALUE_BITS-1:0] FP_NEG_MAX  = 32'hFF7F_FFFF;
   localparam logic [VALUE_BITS-1:0] FP_POS_TINY = 32'h0000_0001;
   localparam logic [VALUE_BITS-1:0] FP_NEG_TINY = 32'h8000_0001;
   localparam logic [VALUE_BITS-1:0] FP_QNAN     = 32'h7FC0_0000;
   localparam logic [VALUE_BITS-1:0] FP_SNAN     = 32'h7F80_0001;
   localparam logic [VALUE_BITS-1:0] FP_NAN_ONES = 32'hFFFF_FFFF;
   localparam logic [VALUE_BITS-1:0] FP_NAN_POS  = 32'h7FFF_FFFF;

   class ranking_board;
      logic [VALUE_BITS-1:0]    top_bits[TOP_COUNT];
      logic [POSITION_BITS-1:0] top_pos[TOP_COUNT];
      int unsigned              filled;
      logic [POSITION_BITS-1:0] next_pos;
      result_type               ranked_due[$];
      int unsigned              errors;

      function new();
         filled   = 0;
         next_pos = '0;
         errors   = 0;
      endfunction

      function logic [VALUE_BITS-1:0] rank_key(logic [VALUE_BITS-1:0] b);
         if (b[VALUE_BITS-2:0] == '0) begin
            return {1'b1, {(VALUE_BITS-1){1'b0}}};
         end
         if (b[VALUE_BITS-1]) begin
            return ~b;
         end
         return {1'b1, b[VALUE_BITS-2:0]};
      endfunction

      function bit nan_pattern(logic [VALUE_BITS-1:0] b);
         return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
      endfunction

      function void take_request(logic [VALUE_BITS-1:0] b, logic eov);
         logic [POSITION_BITS-1:0] pos;
         logic [VALUE_BITS-1:0]    key;
         int                       n;
         int                       slot;
         bit                       drop;
         result_type               r;
         pos = next_pos;
         if (next_pos != POS_MAX) begin
            next_pos = next_pos + 1'b1;
         end
         if (!nan_pattern(b)) begin
            key  = rank_key(b);
            n    = filled;
            drop = 1'b0;
            if (n >= TOP_COUNT) begin
               if (key <= rank_key(top_bits[TOP_COUNT-1])) begin
                  drop = 1'b1;
               end else begin
                  n = TOP_COUNT - 1;
               end
            end
            if (!drop) begin
               // newcomer goes after equal keys
               slot = n;
               while (slot > 0 && rank_key(top_bits[slot-1]) < key) begin
                  top_bits[slot] = top_bits[slot-1];
                  top_pos[slot]  = top_pos[slot-1];
                  slot--;
               end
               top_bits[slot] = b;
               top_pos[slot]  = pos;
               filled = n + 1;
            end
         end
         if (eov) begin
            for (int k = 0; k < filled; k++) begin
               r.rank         = RANK_BITS'(k);
               r.position     = top_pos[k];
               r.kept_bits    = top_bits[k];
               r.final_result = (k + 1 == filled);
               ranked_due.push_back(r);
            end
            filled   = 0;
            next_pos = '0;
         end
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (ranked_due.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual rank %0d pos %0d bits %h last %b",
                     $time, got.rank, got.position, got.kept_bits, got.final_result);
            errors++;
            return;
         end
         want = ranked_due.pop_front();
         if (got.rank !== want.rank) begin
            $display("%0t: rank expected %0d actual %0d", $time, want.rank, got.rank);
            errors++;
         end
         if (got.position !== want.position) begin
            $display("%0t: position expected %0d actual %0d", $time, want.position,
                     got.position);
            errors++;
         end
         if (got.kept_bits !== want.kept_bits) begin
            $display("%0t: kept_bits expected %h actual %h", $time, want.kept_bits,
                     got.kept_bits);
            errors++;
         end
         if (got.final_result !== want.final_result) begin
            $display("%0t: final_result expected %b actual %b", $time, want.final_result,
                     got.final_result);
            errors++;
         end
      endfunction

      function int pending();
         return ranked_due.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        steady;
   int unsigned random_sent;
   int unsigned cycle_count;
   ranking_board board;

   logic [VALUE_BITS-1:0] tie_values[TIE_COUNT] =
      '{FP_POS_ONE, FP_NEG_ONE, FP_POS_ZERO, FP_NEG_ZERO, FP_POS_TWO};
   logic [VALUE_BITS-1:0] extreme_values[EXTREME_COUNT] =
      '{FP_POS_INF, FP_NEG_INF, FP_POS_MAX, FP_NEG_MAX, FP_POS_TINY, FP_NEG_TINY};

   stks_req_if req_ch ();
   stks_rsp_if rsp_ch ();

   stream_top_k_selector_unit dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("stream_top_k_selector_unit_test failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         board.check_result({rsp_ch.rank, rsp_ch.position, rsp_ch.kept_bits,
                             rsp_ch.final_result});
      end
   end

   // receiver, with one long hold-off in the random phase
   initial begin
      bit hold_done;
      hold_done    = 1'b0;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!hold_done && random_sent >= HOLD_AFTER) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end
         rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
         @(negedge clock);
      end
   end

   task automatic send_sample(input logic [VALUE_BITS-1:0] b, input logic eov);
      @(negedge clock);
      while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.sample_bits   <= b;
      req_ch.end_of_vector <= eov;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      board.take_request(b, eov);
   endtask

   function automatic logic [VALUE_BITS-1:0] random_sample();
      logic [VALUE_BITS-1:0] b;
      case ($urandom_range(9))
         0, 1, 2, 3: b = $urandom;
         4, 5:       b = tie_values[$urandom_range(TIE_COUNT-1)];
         6:          b = {1'($urandom_range(1)), 8'hFF, 23'($urandom_range(23'h7F_FFFF, 1))};
         7:          b = extreme_values[$urandom_range(EXTREME_COUNT-1)];
         default:    b = {1'($urandom_range(1)), 8'($urandom_range(140, 110)), 23'($urandom)};
      endcase
      return b;
   endfunction

   task automatic send_random_vector();
      int len;
      len = ($urandom_range(3) == 0) ? $urandom_range(3, 1) : $urandom_range(12, 4);
      for (int k = 0; k < len; k++) begin
         send_sample(random_sample(), k == len - 1);
         random_sent++;
      end
   endtask

   initial begin
      int n;
      board                = new();
      reset                = 1'b1;
      steady               = 1'b0;
      random_sent          = 0;
      req_ch.valid         = 1'b0;
      req_ch.sample_bits   = '0;
      req_ch.end_of_vector = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // single element
      send_sample(FP_POS_ZERO, 1'b1);
      // only nans, no results
      send_sample(FP_QNAN, 1'b0);
      send_sample(FP_SNAN, 1'b0);
      send_sample(FP_NAN_ONES, 1'b1);
      // signed zeros and ties, equal newcomer stays out
      send_sample(FP_NEG_ZERO, 1'b0);
      send_sample(FP_POS_ZERO, 1'b0);
      send_sample(FP_NEG_ZERO, 1'b0);
      send_sample(FP_POS_ZERO, 1'b0);
      send_sample(FP_POS_ZERO, 1'b1);
      // extremes with a nan in between
      send_sample(FP_NEG_INF, 1'b0);
      send_sample(FP_POS_TINY, 1'b0);
      send_sample(FP_NEG_TINY, 1'b0);
      send_sample(FP_POS_MAX, 1'b0);
      send_sample(FP_NAN_POS, 1'b0);
      send_sample(FP_POS_INF, 1'b0);
      send_sample(FP_NEG_MAX, 1'b0);
      send_sample(FP_POS_ONE, 1'b0);
      send_sample(FP_POS_ONE, 1'b1);
      // short vector
      send_sample(FP_NEG_ONE, 1'b0);
      send_sample(FP_POS_TWO, 1'b1);

      n = 0;
      while (random_sent < RANDOM_ITEMS) begin
         steady = (n >= 20 && n < 34);
         send_random_vector();
         n++;
      end
      steady = 1'b0;
      @(negedge clock);
      req_ch.valid <= 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (board.errors == 0) begin
         $display("stream_top_k_selector_unit_test passed");
      end else begin
         $display("stream_top_k_selector_unit_test failed");
      end
      $finish;
   end

endmodule
